/* src/mlb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mlb_pkg;

   // item kinds carried in tuser
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_START = 2'd2,
      KIND_STOP  = 2'd3
   } kind_type;

   // pattern and bit count loaded for one character
   typedef struct packed {
      logic [15:0] code;
      logic [4:0]  nbits;
   } letter_type;

   localparam int          LETTER_COUNT = 26;
   localparam logic [7:0]  CHAR_A       = 8'h41;
   localparam logic [7:0]  CHAR_Z       = 8'h5a;
   localparam logic [4:0]  GAP_BITS     = 5'd4;

   // mark/space patterns, sent lsb first, trailing gap included
   localparam logic [15:0] LETTER_CODE [LETTER_COUNT] = '{
      16'h001d, 16'h0157, 16'h05d7, 16'h0057, 16'h0001, 16'h0175, 16'h0177,
      16'h0055, 16'h0005, 16'h1ddd, 16'h01d7, 16'h015d, 16'h0077, 16'h0017,
      16'h0777, 16'h05dd, 16'h1d77, 16'h005d, 16'h0015, 16'h0007, 16'h0075,
      16'h01d5, 16'h01dd, 16'h0757, 16'h1dd7, 16'h0577
   };

   localparam logic [4:0] LETTER_BITS [LETTER_COUNT] = '{
      5'd8,  5'd12, 5'd14, 5'd10, 5'd4,  5'd12, 5'd12, 5'd10, 5'd6,
      5'd16, 5'd12, 5'd12, 5'd10, 5'd8,  5'd14, 5'd14, 5'd16, 5'd10,
      5'd8,  5'd6,  5'd10, 5'd12, 5'd12, 5'd14, 5'd16, 5'd14
   };

   // letters take their table entry, anything else is a four-tick gap
   function automatic letter_type char_entry(input logic [7:0] ch);
      letter_type  r;
      logic [4:0]  idx;
      idx     = 5'(ch - CHAR_A);
      r.code  = 16'h0000;
      r.nbits = GAP_BITS;
      if (ch >= CHAR_A && ch <= CHAR_Z) begin
         r.code  = LETTER_CODE[idx];
         r.nbits = LETTER_BITS[idx];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/mlb_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlb_store #(
   parameter int DEPTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // single write port, registered read with write-through on a matching address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && wr_addr == rd_addr) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/morse_led_blinker.sv */
`timescale 1ns / 1ps
`default_nettype none
// morse keyer: one result beat per request beat, in order
// path: a request beat is held in the input register, then its result beat in the result register
// throughput: one beat per cycle while rsp_tready does not stall the result register; the next
// character is prefetched from the store so a tick never waits on the registered store read
// reset: synchronous, clears playback state (not first_ff) and both valid bits; store keeps its contents

module morse_led_blinker
   import mlb_pkg::*;
#(
   parameter int MSG_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // char_value[7:0], char_slot[12:8], repeat_flag[13]
   input  wire logic [1:0]  req_tuser,  // kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata   // led[0], active[1]
);

   localparam int AW = $clog2(MSG_DEPTH);
   localparam int PW = $clog2(MSG_DEPTH + 1);
   localparam logic [PW-1:0] POS_END = PW'(MSG_DEPTH);

   // input register
   logic       in_valid_ff;
   kind_type   in_kind_ff;
   logic [7:0] in_char_ff;
   logic [4:0] in_slot_ff;
   logic       in_rep_ff;

   // result register
   logic       out_valid_ff;
   logic       out_led_ff;
   logic       out_active_ff;

   // playback state
   logic          running_ff,  running_in;
   logic          repeat_ff,   repeat_in;
   logic [PW-1:0] read_pos_ff, read_pos_in;
   logic [15:0]   pattern_ff,  pattern_in;
   logic [4:0]    bits_ff,     bits_in;
   logic [7:0]    first_ff,    first_in;

   logic          advance;
   logic          fire;
   logic          led_c;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // handshake: the result register parts the two sides
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign fire       = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_kind_ff <= kind_type'(req_tuser);
         in_char_ff <= req_tdata[7:0];
         in_slot_ff <= req_tdata[12:8];
         in_rep_ff  <= req_tdata[13];
      end
   end

   // store write from a write beat inside the store
   assign wr_en   = fire && in_kind_ff == KIND_WRITE && 32'(in_slot_ff) < 32'(MSG_DEPTH);
   assign wr_addr = AW'(in_slot_ff);
   assign first_in = (wr_en && in_slot_ff == 5'd0) ? in_char_ff : first_ff;

   // prefetch the byte at the position the keyer will hold next cycle
   assign rd_addr = (reset || read_pos_in >= POS_END) ? '0 : AW'(read_pos_in);

   mlb_store #(
      .DEPTH (MSG_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_char_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next playback state for the beat in the input register
   always_comb begin
      logic [7:0]  ch;
      logic        send;
      logic [15:0] pat_cur;
      logic [4:0]  bits_cur;
      letter_type  entry;
      running_in  = running_ff;
      repeat_in   = repeat_ff;
      read_pos_in = read_pos_ff;
      pattern_in  = pattern_ff;
      bits_in     = bits_ff;
      led_c       = 1'b0;
      ch          = 8'h00;
      send        = 1'b1;
      pat_cur     = pattern_ff;
      bits_cur    = bits_ff;
      entry       = char_entry(8'h00);
      if (fire) begin
         case (in_kind_ff)
            KIND_TICK: begin
               if (running_ff) begin
                  // pattern used up: fetch the next character
                  if (bits_ff == 5'd0) begin
                     if (read_pos_ff < POS_END) begin
                        ch          = rd_data;
                        read_pos_in = read_pos_ff + PW'(1);
                     end
                     if (ch == 8'h00) begin
                        if (repeat_ff) begin
                           ch          = first_ff;
                           read_pos_in = PW'(1);
                        end else begin
                           running_in  = 1'b0;
                           read_pos_in = '0;
                           send        = 1'b0;
                        end
                     end
                     entry    = char_entry(ch);
                     pat_cur  = entry.code;
                     bits_cur = entry.nbits;
                  end
                  // shift one bit out
                  if (send) begin
                     led_c      = pat_cur[0];
                     pattern_in = pat_cur >> 1;
                     bits_in    = bits_cur - 5'd1;
                  end
               end
            end
            KIND_WRITE: begin
            end
            KIND_START: begin
               repeat_in   = in_rep_ff;
               read_pos_in = '0;
               running_in  = 1'b1;
               pattern_in  = 16'h0000;
               bits_in     = 5'd0;
            end
            default: begin
               running_in  = 1'b0;
               read_pos_in = '0;
               pattern_in  = 16'h0000;
               bits_in     = 5'd0;
            end
         endcase
      end
   end

   // playback state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         repeat_ff   <= 1'b0;
         read_pos_ff <= '0;
         pattern_ff  <= 16'h0000;
         bits_ff     <= 5'd0;
      end else begin
         running_ff  <= running_in;
         repeat_ff   <= repeat_in;
         read_pos_ff <= read_pos_in;
         pattern_ff  <= pattern_in;
         bits_ff     <= bits_in;
      end
      first_ff <= first_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         out_led_ff    <= led_c;
         out_active_ff <= running_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, out_active_ff, out_led_ff};

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
   import mlb_pkg::*;
;

   localparam int MSG_DEPTH   = 32;
   localparam int TOTAL_BEATS = 1650;
   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PCT    = 17;

   // expected mark/space patterns per letter, lsb first, and their lengths
   localparam logic [15:0] MORSE_PATTERN [26] = '{
      16'h001d, 16'h0157, 16'h05d7, 16'h0057, 16'h0001, 16'h0175, 16'h0177,
      16'h0055, 16'h0005, 16'h1ddd, 16'h01d7, 16'h015d, 16'h0077, 16'h0017,
      16'h0777, 16'h05dd, 16'h1d77, 16'h005d, 16'h0015, 16'h0007, 16'h0075,
      16'h01d5, 16'h01dd, 16'h0757, 16'h1dd7, 16'h0577
   };
   localparam int MORSE_LENGTH [26] = '{
      8, 12, 14, 10, 4, 12, 12, 10, 6, 16, 12, 12, 10,
      8, 14, 14, 16, 10, 8, 6, 10, 12, 12, 14, 16, 14
   };
   localparam int SPACE_TICKS = 4;

   typedef struct packed {
      logic led;
      logic active;
   } lamp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'h0000;  // char_value[7:0], char_slot[12:8], repeat_flag[13]
   logic [1:0]  req_tuser  = KIND_TICK; // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;              // led[0], active[1]

   // keyer state as the testbench sees it
   logic [7:0]  msg_mem [MSG_DEPTH];
   bit          mem_written [MSG_DEPTH];
   int          next_pos;
   bit          play_on;
   bit          play_loop;
   logic [15:0] shift_reg;
   int          bits_due;

   lamp_type    led_states_due[$];
   int          sent_beats;
   int          mismatch_count;
   int          cycle_count;
   bit          calm;

   morse_led_blinker #(.MSG_DEPTH(MSG_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // load the pattern for one character, non-letters are a space
   function automatic void load_pattern(logic [7:0] ch);
      int idx;
      idx = int'(ch) - int'(CHAR_A);
      if (ch >= CHAR_A && ch <= CHAR_Z) begin
         shift_reg = MORSE_PATTERN[idx];
         bits_due  = MORSE_LENGTH[idx];
      end else begin
         shift_reg = 16'h0000;
         bits_due  = SPACE_TICKS;
      end
   endfunction

   // led and active for one accepted beat, advancing the keyer state
   function automatic lamp_type keyer_next(kind_type k, logic [7:0] v, logic [4:0] s, logic r);
      lamp_type   o;
      logic [7:0] ch;
      o.led = 1'b0;
      case (k)
         KIND_TICK: begin
            if (play_on && bits_due == 0) begin
               ch = 8'h00;
               if (next_pos < MSG_DEPTH) begin
                  ch = msg_mem[next_pos];
                  next_pos++;
               end
               if (ch == 8'h00) begin
                  if (play_loop) begin
                     ch       = msg_mem[0];
                     next_pos = 1;
                  end else begin
                     play_on  = 1'b0;
                     next_pos = 0;
                  end
               end
               if (play_on) load_pattern(ch);
            end
            if (play_on) begin
               o.led     = shift_reg[0];
               shift_reg = shift_reg >> 1;
               bits_due--;
            end
         end
         KIND_WRITE: begin
            if (int'(s) < MSG_DEPTH) begin
               msg_mem[s]     = v;
               mem_written[s] = 1'b1;
            end
         end
         KIND_START: begin
            play_loop = r;
            play_on   = 1'b1;
            next_pos  = 0;
            shift_reg = 16'h0000;
            bits_due  = 0;
         end
         default: begin
            play_on   = 1'b0;
            next_pos  = 0;
            shift_reg = 16'h0000;
            bits_due  = 0;
         end
      endcase
      o.active = play_on;
      return o;
   endfunction

   // slot that the next tick would fetch without it ever being written, or -1
   function automatic int unwritten_fetch();
      if (!play_on || bits_due != 0) return -1;
      if (next_pos < MSG_DEPTH) begin
         if (!mem_written[next_pos]) return next_pos;
         if (msg_mem[next_pos] != 8'h00) return -1;
      end
      if (play_loop && !mem_written[0]) return 0;
      return -1;
   endfunction

   function automatic logic [7:0] random_char(bit mostly_spaces);
      int pick;
      pick = $urandom_range(99);
      if (pick < (mostly_spaces ? 15 : 60)) return 8'(int'(CHAR_A) + $urandom_range(25));
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // one request beat, with random idle cycles in front of it
   task automatic send_item(kind_type k, logic [7:0] v, logic [4:0] s, logic r);
      calm = (sent_beats >= 700 && sent_beats < 1000);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {2'b00, r, s, v};
      do @(posedge clock); while (!req_tready);
      led_states_due.push_back(keyer_next(k, v, s, r));
      sent_beats++;
   endtask

   // a tick never fetches an unwritten slot: fill it first
   task automatic send_tick();
      int slot;
      slot = unwritten_fetch();
      while (slot >= 0) begin
         send_item(KIND_WRITE, random_char(1'b0), 5'(slot), 1'($urandom_range(1)));
         slot = unwritten_fetch();
      end
      send_item(KIND_TICK, 8'($urandom_range(255)), 5'($urandom_range(31)),
                1'($urandom_range(1)));
   endtask

   // letter, lowercase space, then terminator without repeat
   task automatic test_plain_message();
      send_item(KIND_WRITE, "E", 5'd0, 1'b1);
      send_item(KIND_WRITE, "a", 5'd1, 1'b0);
      send_item(KIND_WRITE, 8'h00, 5'd2, 1'b1);
      send_item(KIND_START, 8'hff, 5'd31, 1'b0);
      repeat (9) send_tick();
   endtask

   // terminator with repeat wraps to a first byte that is not a letter
   task automatic test_repeat_wrap();
      send_item(KIND_WRITE, 8'hff, 5'd0, 1'b0);
      send_item(KIND_WRITE, 8'h00, 5'd1, 1'b1);
      send_item(KIND_START, 8'h00, 5'd0, 1'b1);
      repeat (6) send_tick();
   endtask

   // start while playing drops the pattern, stop idles the keyer
   task automatic test_restart_and_stop();
      send_item(KIND_START, 8'h00, 5'd0, 1'b0);
      send_tick();
      send_item(KIND_STOP, 8'hff, 5'd31, 1'b1);
      send_tick();
   endtask

   // random messages, mostly short, some filling the whole store
   task automatic test_random_traffic();
      int pick;
      int len;
      int budget;
      while (sent_beats < TOTAL_BEATS) begin
         pick = $urandom_range(99);
         len  = (pick < 70) ? $urandom_range(1, 5) :
                (pick < 85) ? $urandom_range(6, 31) : MSG_DEPTH;
         for (int i = 0; i < len; i++)
            send_item(KIND_WRITE, random_char(len == MSG_DEPTH), 5'(i), 1'($urandom_range(1)));
         if (len < MSG_DEPTH)
            send_item(KIND_WRITE, 8'h00, 5'(len), 1'($urandom_range(1)));
         // empty message now and then
         if ($urandom_range(9) == 0)
            send_item(KIND_WRITE, 8'h00, 5'd0, 1'($urandom_range(1)));
         send_item(KIND_START, 8'($urandom_range(255)), 5'($urandom_range(31)),
                   1'($urandom_range(1)));
         budget = (len == MSG_DEPTH) ? 220 : $urandom_range(10, 160);
         for (int t = 0; t < budget && play_on; t++) begin
            pick = $urandom_range(99);
            if (pick < 2)
               send_item(KIND_START, 8'($urandom_range(255)), 5'($urandom_range(31)),
                         1'($urandom_range(1)));
            else if (pick < 4)
               send_item(KIND_STOP, 8'($urandom_range(255)), 5'($urandom_range(31)),
                         1'($urandom_range(1)));
            else if (pick < 7)
               send_item(KIND_WRITE, 8'($urandom_range(255)), 5'($urandom_range(31)),
                         1'($urandom_range(1)));
            else
               send_tick();
         end
         if (play_on && $urandom_range(1))
            send_item(KIND_STOP, 8'($urandom_range(255)), 5'($urandom_range(31)),
                      1'($urandom_range(1)));
         repeat ($urandom_range(0, 2)) send_tick();
      end
   endtask

   // sink side stalls at random, except in the calm stretch
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // compare each result beat with the oldest expected led state
   always @(posedge clock) begin
      lamp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (led_states_due.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = led_states_due.pop_front();
            if (rsp_tdata[0] !== want.led)
               report_mismatch($sformatf("led %b, expected %b", rsp_tdata[0], want.led));
            if (rsp_tdata[1] !== want.active)
               report_mismatch($sformatf("active %b, expected %b", rsp_tdata[1], want.active));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      next_pos       = 0;
      play_on        = 1'b0;
      play_loop      = 1'b0;
      shift_reg      = 16'h0000;
      bits_due       = 0;
      sent_beats     = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      calm           = 1'b0;
      foreach (mem_written[i]) mem_written[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_plain_message();
      test_repeat_wrap();
      test_restart_and_stop();
      test_random_traffic();

      req_tvalid <= 1'b0;
      while (led_states_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* files.f */
src/mlb_pkg.sv
src/mlb_store.sv
src/morse_led_blinker.sv
dv/tb_top.sv
